FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the summed-volume box-sum block.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IVBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ivbs assertion failed");

// Check that a condition never holds outside reset.
`define IVBS_ASSERT_NEVER(lbl, cond) \
  `IVBS_ASSERT(lbl, !(cond))

`endif

FILE: rtl/ivbs_pkg.sv
// Shared types and constants of the summed-volume box-sum block.
// No dependencies; used by every module of the block.
package ivbs_pkg;

  // Field widths
  localparam int unsigned SUM_W     = 31;
  localparam int unsigned VOXEL_W   = 16;
  localparam int unsigned START_W   = 5;
  localparam int unsigned EXT_W     = 6;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 2;

  // Default volume limits
  localparam int unsigned DEF_MAX_X = 32;
  localparam int unsigned DEF_MAX_Y = 32;
  localparam int unsigned DEF_MAX_Z = 32;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BOX       = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [VOXEL_W-1:0] voxel_value;
    logic [START_W-1:0] box_x;
    logic [START_W-1:0] box_y;
    logic [START_W-1:0] box_z;
    logic [EXT_W-1:0]   box_w;
    logic [EXT_W-1:0]   box_h;
    logic [EXT_W-1:0]   box_d;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]    box_sum;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

FILE: rtl/ivbs_table_mem.sv
// Summed-volume table storage: one write port, one read port, registered read data.
// Depends on ivbs_pkg for the default entry width.
module ivbs_table_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15,
  parameter int unsigned DW    = ivbs_pkg::SUM_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/integral_volume_box_sum.sv
// Top level of the summed-volume box-sum block: sequencer, shared accumulator, table.
// Depends on ivbs_pkg, ivbs_table_mem and assert_macros.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | into      | in_valid_i / in_ready_o | in_item_i  (ivbs_pkg::in_item_t)
//  out     | out of    | out_valid_o/out_ready_i | out_item_o (ivbs_pkg::out_item_t)
//  cfg     | into      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load item makes three neighbour reads, then a drain step and one table write.
// A query forms four address products on the shared multiplier, makes eight
// corner reads through the single table read port, then drains and gives its result.
// A query refused for status goes straight to the result step. Items are taken one at a time.
// The output register lets the next item be accepted while a result waits.
// Reset clears the control state only; the table holds nothing until loaded.
`include "assert_macros.svh"

module integral_volume_box_sum #(
  parameter int unsigned MAX_X = ivbs_pkg::DEF_MAX_X,
  parameter int unsigned MAX_Y = ivbs_pkg::DEF_MAX_Y,
  parameter int unsigned MAX_Z = ivbs_pkg::DEF_MAX_Z
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ivbs_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ivbs_pkg::out_item_t                out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ivbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ivbs_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned SW    = ivbs_pkg::SUM_W;
  localparam int unsigned CW    = ivbs_pkg::CFG_W;
  localparam int unsigned EW1   = ivbs_pkg::EXT_W + 1;
  localparam int unsigned DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int unsigned PLANE = MAX_X * MAX_Y;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int unsigned YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int unsigned ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam logic [AW-1:0] ROW_STEP   = AW'(MAX_Y);
  localparam logic [AW-1:0] PLANE_STEP = AW'(PLANE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_RESULT
  } state_e;

  function automatic logic [CW-1:0] eff_size(logic [CW-1:0] v, int unsigned maxv);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CW'(1);
    end else if (int'(v) > int'(maxv)) begin
      r = CW'(maxv);
    end
    return r;
  endfunction

  // Control state
  state_e                     state_q, state_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       kind_q, kind_d;
  logic [CW-1:0]              size_x_q, size_x_d, size_y_q, size_y_d, size_z_q, size_z_d;
  logic [XW-1:0]              pos_x_q, pos_x_d;
  logic [YW-1:0]              pos_y_q, pos_y_d;
  logic [ZW-1:0]              pos_z_q, pos_z_d;
  logic [AW-1:0]              row_base_q, row_base_d, plane_base_q, plane_base_d;
  logic [SW-1:0]              row_sum_q, row_sum_d;
  logic                       ready_q, ready_d;
  logic                       rd_vld_q, rd_vld_d, rd_sub_q, rd_sub_d, rd_use_q, rd_use_d;
  logic                       out_valid_q, out_valid_d;

  // Datapath state
  logic [SW-1:0]              acc_q, acc_d;
  logic [AW-1:0]              load_addr_q, load_addr_d;
  logic [XW-1:0]              xlo_q, xlo_d, xhi_q, xhi_d;
  logic [YW-1:0]              ylo_q, ylo_d, yhi_q, yhi_d;
  logic [ZW-1:0]              zlo_q, zlo_d, zhi_q, zhi_d;
  logic                       use_xlo_q, use_xlo_d, use_ylo_q, use_ylo_d;
  logic                       use_zlo_q, use_zlo_d;
  logic [ivbs_pkg::STATUS_W-1:0] status_q, status_d;
  logic [AW-1:0]              zt_q [2];
  logic [AW-1:0]              zt_d [2];
  logic [AW-1:0]              xt_q [2];
  logic [AW-1:0]              xt_d [2];
  ivbs_pkg::out_item_t        out_item_q, out_item_d;

  // Combinational helpers
  logic [CW-1:0]              eff_x, eff_y, eff_z;
  logic [EW1-1:0]             x_end, y_end, z_end;
  logic [SW-1:0]              row_new;
  logic [AW-1:0]              mul_a, mul_b, mul_p;
  logic [AW-1:0]              step_addr;
  logic                       step_use, step_sub, last_step;
  logic                       iz, ix, iy;
  logic                       in_acc, cfg_acc;
  logic                       mem_we, mem_re;
  logic [SW-1:0]              rdata;

  assign eff_x = eff_size(size_x_q, MAX_X);
  assign eff_y = eff_size(size_y_q, MAX_Y);
  assign eff_z = eff_size(size_z_q, MAX_Z);

  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Box end points and running row sum of the incoming item
  assign x_end   = EW1'(in_item_i.box_x) + EW1'(in_item_i.box_w);
  assign y_end   = EW1'(in_item_i.box_y) + EW1'(in_item_i.box_h);
  assign z_end   = EW1'(in_item_i.box_z) + EW1'(in_item_i.box_d);
  assign row_new = (pos_y_q == '0) ? SW'(in_item_i.voxel_value)
                                   : row_sum_q + SW'(in_item_i.voxel_value);

  // Shared multiplier: corner coordinate times a row or plane stride
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    mul_a = AW'(zlo_q);
      2'd1:    mul_a = AW'(zhi_q);
      2'd2:    mul_a = AW'(xlo_q);
      default: mul_a = AW'(xhi_q);
    endcase
    mul_b = cnt_q[1] ? ROW_STEP : PLANE_STEP;
    mul_p = mul_a * mul_b;
  end

  // Address, sign and mask of the current read step
  assign iz = cnt_q[2];
  assign ix = cnt_q[1];
  assign iy = cnt_q[0];

  always_comb begin
    step_addr = '0;
    step_use  = 1'b0;
    step_sub  = 1'b0;
    if (kind_q == ivbs_pkg::KIND_LOAD) begin
      last_step = (cnt_q == 3'd2);
      case (cnt_q)
        3'd0: begin
          step_use  = (pos_x_q != '0);
          step_addr = load_addr_q - ROW_STEP;
        end
        3'd1: begin
          step_use  = (pos_z_q != '0);
          step_addr = load_addr_q - PLANE_STEP;
        end
        3'd2: begin
          step_use  = (pos_x_q != '0) && (pos_z_q != '0);
          step_sub  = 1'b1;
          step_addr = load_addr_q - ROW_STEP - PLANE_STEP;
        end
        default: begin
          step_use = 1'b0;
        end
      endcase
    end else begin
      last_step = (cnt_q == 3'd7);
      step_use  = (iz || use_zlo_q) && (ix || use_xlo_q) && (iy || use_ylo_q);
      step_sub  = ~(iz ^ ix ^ iy);
      step_addr = (iz ? zt_q[1] : zt_q[0]) + (ix ? xt_q[1] : xt_q[0])
                + AW'(iy ? yhi_q : ylo_q);
    end
    // Park a masked corner on a harmless address
    if (!step_use) begin
      step_addr = '0;
    end
  end

  assign mem_re = (state_q == ST_RUN);
  assign mem_we = (state_q == ST_WRITE);

  // Sequencer and datapath next state
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    kind_d       = kind_q;
    size_x_d     = size_x_q;
    size_y_d     = size_y_q;
    size_z_d     = size_z_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    pos_z_d      = pos_z_q;
    row_base_d   = row_base_q;
    plane_base_d = plane_base_q;
    row_sum_d    = row_sum_q;
    ready_d      = ready_q;
    rd_vld_d     = mem_re;
    rd_sub_d     = step_sub;
    rd_use_d     = step_use;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    acc_d        = acc_q;
    load_addr_d  = load_addr_q;
    xlo_d        = xlo_q;
    xhi_d        = xhi_q;
    ylo_d        = ylo_q;
    yhi_d        = yhi_q;
    zlo_d        = zlo_q;
    zhi_d        = zhi_q;
    use_xlo_d    = use_xlo_q;
    use_ylo_d    = use_ylo_q;
    use_zlo_d    = use_zlo_q;
    status_d     = status_q;
    zt_d         = zt_q;
    xt_d         = xt_q;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Accumulate the read data of the previous step
    if (rd_vld_q && rd_use_q) begin
      acc_d = rd_sub_q ? (acc_q - rdata) : (acc_q + rdata);
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          // A size write restarts loading
          case (cfg_index_i)
            ivbs_pkg::REG_SIZE_X: size_x_d = cfg_data_i;
            ivbs_pkg::REG_SIZE_Y: size_y_d = cfg_data_i;
            ivbs_pkg::REG_SIZE_Z: size_z_d = cfg_data_i;
            default:              size_x_d = size_x_q;
          endcase
          if (cfg_index_i == ivbs_pkg::REG_SIZE_X || cfg_index_i == ivbs_pkg::REG_SIZE_Y ||
              cfg_index_i == ivbs_pkg::REG_SIZE_Z) begin
            pos_x_d      = '0;
            pos_y_d      = '0;
            pos_z_d      = '0;
            row_base_d   = '0;
            plane_base_d = '0;
            row_sum_d    = '0;
            ready_d      = 1'b0;
          end
        end else if (in_acc) begin
          kind_d = in_item_i.kind;
          cnt_d  = '0;
          if (in_item_i.kind == ivbs_pkg::KIND_LOAD) begin
            if (pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0) begin
              ready_d = 1'b0;
            end
            row_sum_d   = row_new;
            acc_d       = row_new;
            load_addr_d = row_base_q + AW'(pos_y_q);
            state_d     = ST_RUN;
          end else begin
            acc_d     = '0;
            xlo_d     = XW'(EW1'(in_item_i.box_x) - EW1'(1));
            ylo_d     = YW'(EW1'(in_item_i.box_y) - EW1'(1));
            zlo_d     = ZW'(EW1'(in_item_i.box_z) - EW1'(1));
            xhi_d     = XW'(x_end - EW1'(1));
            yhi_d     = YW'(y_end - EW1'(1));
            zhi_d     = ZW'(z_end - EW1'(1));
            use_xlo_d = (in_item_i.box_x != '0);
            use_ylo_d = (in_item_i.box_y != '0);
            use_zlo_d = (in_item_i.box_z != '0);
            if (!ready_q) begin
              status_d = ivbs_pkg::STATUS_NOT_READY;
              state_d  = ST_RESULT;
            end else if (in_item_i.box_w == '0 || in_item_i.box_h == '0 ||
                         in_item_i.box_d == '0 || x_end > EW1'(eff_x) ||
                         y_end > EW1'(eff_y) || z_end > EW1'(eff_z)) begin
              status_d = ivbs_pkg::STATUS_BOX;
              state_d  = ST_RESULT;
            end else begin
              status_d = ivbs_pkg::STATUS_OK;
              state_d  = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        // Form the plane and row offsets of the corners
        if (cnt_q[1]) begin
          xt_d[cnt_q[0]] = mul_p;
        end else begin
          zt_d[cnt_q[0]] = mul_p;
        end
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          state_d = ST_RUN;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        state_d = (kind_q == ivbs_pkg::KIND_LOAD) ? ST_WRITE : ST_RESULT;
      end
      ST_WRITE: begin
        // Advance the load position in storage order
        state_d = ST_IDLE;
        if (int'(pos_y_q) + 1 >= int'(eff_y)) begin
          pos_y_d = '0;
          if (int'(pos_x_q) + 1 >= int'(eff_x)) begin
            pos_x_d = '0;
            if (int'(pos_z_q) + 1 >= int'(eff_z)) begin
              pos_z_d      = '0;
              row_base_d   = '0;
              plane_base_d = '0;
              ready_d      = 1'b1;
            end else begin
              pos_z_d      = pos_z_q + ZW'(1);
              plane_base_d = plane_base_q + PLANE_STEP;
              row_base_d   = plane_base_q + PLANE_STEP;
            end
          end else begin
            pos_x_d    = pos_x_q + XW'(1);
            row_base_d = row_base_q + ROW_STEP;
          end
        end else begin
          pos_y_d = pos_y_q + YW'(1);
        end
      end
      ST_RESULT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_item_d.status  = status_q;
          out_item_d.box_sum = (status_q == ivbs_pkg::STATUS_OK) ? acc_q : '0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      kind_q       <= ivbs_pkg::KIND_LOAD;
      size_x_q     <= ivbs_pkg::SIZE_RESET;
      size_y_q     <= ivbs_pkg::SIZE_RESET;
      size_z_q     <= ivbs_pkg::SIZE_RESET;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      pos_z_q      <= '0;
      row_base_q   <= '0;
      plane_base_q <= '0;
      row_sum_q    <= '0;
      ready_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_sub_q     <= 1'b0;
      rd_use_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      kind_q       <= kind_d;
      size_x_q     <= size_x_d;
      size_y_q     <= size_y_d;
      size_z_q     <= size_z_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      pos_z_q      <= pos_z_d;
      row_base_q   <= row_base_d;
      plane_base_q <= plane_base_d;
      row_sum_q    <= row_sum_d;
      ready_q      <= ready_d;
      rd_vld_q     <= rd_vld_d;
      rd_sub_q     <= rd_sub_d;
      rd_use_q     <= rd_use_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    load_addr_q <= load_addr_d;
    xlo_q       <= xlo_d;
    xhi_q       <= xhi_d;
    ylo_q       <= ylo_d;
    yhi_q       <= yhi_d;
    zlo_q       <= zlo_d;
    zhi_q       <= zhi_d;
    use_xlo_q   <= use_xlo_d;
    use_ylo_q   <= use_ylo_d;
    use_zlo_q   <= use_zlo_d;
    status_q    <= status_d;
    zt_q        <= zt_d;
    xt_q        <= xt_d;
    out_item_q  <= out_item_d;
  end

  ivbs_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_addr_q),
    .wdata_i (acc_q),
    .re_i    (mem_re),
    .raddr_i (step_addr),
    .rdata_o (rdata)
  );

  // Refused queries carry no sum
  `IVBS_ASSERT(a_err_sum_zero,
    out_valid_o && out_item_o.status != ivbs_pkg::STATUS_OK |-> out_item_o.box_sum == '0)
  // The load position never leaves the configured volume
  `IVBS_ASSERT(a_pos_in_volume,
    int'(pos_x_q) < int'(eff_x) && int'(pos_y_q) < int'(eff_y) && int'(pos_z_q) < int'(eff_z))
  // The volume completes only on a table write
  `IVBS_ASSERT(a_ready_on_write, $rose(ready_q) |-> $past(state_q) == ST_WRITE)
  // Read data only arrives behind a read step
  `IVBS_ASSERT_NEVER(a_rd_outside_run,
    rd_vld_q && !(state_q == ST_RUN || state_q == ST_DRAIN))

endmodule
